### rtl/cwh_pkg.sv
package cwh_pkg;

    localparam int MAX_CUTS_DEF = 16;
    localparam int MAX_BINS_DEF = 64;

    localparam int SUM_W   = 40;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;
    localparam int BIN_W   = 8;
    localparam int NCUT_W  = 5;
    localparam int NBIN_W  = 7;
    localparam int CNT_W   = 5;
    localparam int MASK_W  = 16;

    typedef enum logic [CIDX_W-1:0] {
        CFG_RELEVANT_MODE  = 3'd0,
        CFG_RELEVANT_INDEX = 3'd1,
        CFG_NUM_CUTS       = 3'd2,
        CFG_NUM_BINS       = 3'd3,
        CFG_X_MIN          = 3'd4,
        CFG_BIN_SCALE      = 3'd5
    } cfg_index_t;

    typedef enum logic {
        MODE_FILL = 1'b0,
        MODE_READ = 1'b1
    } item_mode_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
        logic signed [15:0] weight;
        logic [15:0]        cut_mask;
        logic [4:0]         hist_select;
        logic [6:0]         bin_select;
    } item_t;

    typedef struct packed {
        logic signed [39:0] bin_total;
        logic [4:0]         histos_filled;
        logic [6:0]         bin_used;
        logic               saturated;
    } result_t;

endpackage

### rtl/cutflow_weighted_histogram.sv
// Cutflow weighted histogram bank.
//
// Items arrive on cmd and are taken at a clock edge where start is high and
// busy is low. A fill item bins its value and adds its weight to that bin in
// every histogram whose cut condition holds; a read item returns one bin sum.
// Every item produces exactly one result transfer on result, marked by done
// for a single cycle. The receiver cannot hold results off, and none is needed:
// the result register is loaded once per item and the next item may be taken
// in the same cycle that done is shown.
//
// Sequence: a read goes through S_READ and S_READ_WAIT to done. A fill goes
// through S_DIFF, S_MUL and S_SETUP and ends there when no histogram is
// updated; otherwise S_FILL reads each updated histogram (1 to 17 with the
// default sizes) and S_FLUSH ends it. The fill length is set by the single
// bin memory: one read-modify-write per histogram, pipelined one per cycle.
//
// After reset the block runs a clearing pass that zeroes all the
// (MAX_CUTS+1)*(MAX_BINS+2) bin sums (1122 by default), one entry per cycle,
// with busy high. Configuration writes on cfg_we/cfg_index/cfg_data are taken
// at any time, including during the clearing pass, and never clear the sums.
module cutflow_weighted_histogram #(
    parameter int MAX_CUTS = cwh_pkg::MAX_CUTS_DEF,
    parameter int MAX_BINS = cwh_pkg::MAX_BINS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  cwh_pkg::item_t             cmd,
    output logic                       done,
    output cwh_pkg::result_t           result,
    input  logic                       cfg_we,
    input  logic [cwh_pkg::CIDX_W-1:0] cfg_index,
    input  logic [cwh_pkg::CFG_W-1:0]  cfg_data
);
    import cwh_pkg::*;

    localparam int ROW    = MAX_BINS + 2;
    localparam int NHIST  = MAX_CUTS + 1;
    localparam int DEPTH  = NHIST * ROW;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_CLEAR     = 9'b000000010,
        S_DIFF      = 9'b000000100,
        S_MUL       = 9'b000001000,
        S_SETUP     = 9'b000010000,
        S_FILL      = 9'b000100000,
        S_FLUSH     = 9'b001000000,
        S_READ      = 9'b010000000,
        S_READ_WAIT = 9'b100000000
    } state_t;

    // Configuration registers.
    logic               relevant_mode_reg;
    logic [3:0]         relevant_index_reg;
    logic [NCUT_W-1:0]  num_cuts_reg;
    logic [NBIN_W-1:0]  num_bins_reg;
    logic signed [31:0] x_min_reg;
    logic [31:0]        bin_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relevant_mode_reg  <= 1'b0;
            relevant_index_reg <= '0;
            num_cuts_reg       <= NCUT_W'(16);
            num_bins_reg       <= NBIN_W'(64);
            x_min_reg          <= '0;
            bin_scale_reg      <= 32'h0001_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RELEVANT_MODE:  relevant_mode_reg  <= cfg_data[0];
                CFG_RELEVANT_INDEX: relevant_index_reg <= cfg_data[3:0];
                CFG_NUM_CUTS:       num_cuts_reg       <= cfg_data[NCUT_W-1:0];
                CFG_NUM_BINS:       num_bins_reg       <= cfg_data[NBIN_W-1:0];
                CFG_X_MIN:          x_min_reg          <= cfg_data;
                CFG_BIN_SCALE:      bin_scale_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Effective sizes: zero counts act as one, oversized counts are clamped.
    logic [NCUT_W-1:0] n_eff;
    logic [NBIN_W-1:0] nb_eff;
    logic [NCUT_W:0]   nh_eff;

    always_comb
    begin
        if (num_cuts_reg == '0)
        begin
            n_eff = NCUT_W'(1);
        end
        else if (32'(num_cuts_reg) > MAX_CUTS)
        begin
            n_eff = NCUT_W'(MAX_CUTS);
        end
        else
        begin
            n_eff = num_cuts_reg;
        end

        if (num_bins_reg == '0)
        begin
            nb_eff = NBIN_W'(1);
        end
        else if (32'(num_bins_reg) > MAX_BINS)
        begin
            nb_eff = NBIN_W'(MAX_BINS);
        end
        else
        begin
            nb_eff = num_bins_reg;
        end
    end

    assign nh_eff = (NCUT_W + 1)'(n_eff) + (NCUT_W + 1)'(relevant_mode_reg);

    // Control and datapath registers.
    state_t             state_reg, state_next;
    item_t              cmd_reg;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic               wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]  wb_addr_reg, wb_addr_next;
    logic               sat_reg, sat_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    // Binning pipeline, fed from the captured item.
    logic [BIN_W-1:0] bin_calc;

    cwh_binner u_binner (
        .clk       (clk),
        .value     (cmd_reg.value),
        .x_min     (x_min_reg),
        .bin_scale (bin_scale_reg),
        .nb        (nb_eff),
        .bin       (bin_calc)
    );

    // Cut classification of the captured item.
    logic [MASK_W-1:0] used_mask;
    logic [MASK_W-1:0] need_mask;
    logic [MASK_W-1:0] cuts;
    logic [CNT_W-1:0]  lead;
    logic              lead_stop;
    logic              need_ok;
    logic [CNT_W-1:0]  fill_count;
    logic              skip_first;

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            used_mask[i] = (i < 32'(n_eff));
        end
        cuts      = cmd_reg.cut_mask & used_mask;
        need_mask = used_mask;
        if (32'(relevant_index_reg) < 32'(n_eff))
        begin
            need_mask[relevant_index_reg] = 1'b0;
        end
        need_ok = ((cuts & need_mask) == need_mask);

        // Number of consecutive passed cuts counted from cut 0.
        lead      = '0;
        lead_stop = 1'b0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (!lead_stop && cuts[i])
            begin
                lead = lead + CNT_W'(1);
            end
            else
            begin
                lead_stop = 1'b1;
            end
        end

        // The updated histograms form one contiguous run; in relevant mode it
        // starts at histogram 1 when the n-minus-one condition fails.
        if (relevant_mode_reg)
        begin
            skip_first = !need_ok;
            fill_count = lead + CNT_W'(need_ok);
        end
        else
        begin
            skip_first = 1'b0;
            fill_count = lead;
        end
    end

    // Memory ports.
    logic                    mem_rd_en;
    logic [ADDR_W-1:0]       mem_rd_addr;
    logic signed [SUM_W-1:0] mem_rd_data;
    logic                    mem_wr_en;
    logic [ADDR_W-1:0]       mem_wr_addr;
    logic signed [SUM_W-1:0] mem_wr_data;

    cwh_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Saturating add of the weight to the bin sum read back from memory.
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic                    sat_now;

    always_comb
    begin
        sum_wide = (SUM_W + 1)'(mem_rd_data) + (SUM_W + 1)'(cmd_reg.weight);
        sat_now  = (sum_wide[SUM_W] != sum_wide[SUM_W-1]);
        if (!sat_now)
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        else if (sum_wide[SUM_W])
        begin
            sum_sat = {1'b1, {(SUM_W - 1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(SUM_W - 1){1'b1}}};
        end
    end

    // Address of a read item, and whether it falls in the active range.
    logic              rd_in_range;
    logic [ADDR_W-1:0] rd_item_addr;

    always_comb
    begin
        rd_in_range = ((NCUT_W + 1)'(cmd_reg.hist_select) < nh_eff)
                   && (32'(cmd_reg.hist_select) < NHIST)
                   && (BIN_W'(cmd_reg.bin_select) <= BIN_W'(nb_eff) + BIN_W'(1));
        rd_item_addr = ADDR_W'(32'(cmd_reg.hist_select) * ROW
                               + 32'(cmd_reg.bin_select));
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        base_next     = base_reg;
        rem_next      = rem_reg;
        filled_next   = filled_reg;
        bin_next      = bin_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        sat_next      = sat_reg;
        rd_ok_next    = rd_ok_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        mem_rd_en   = 1'b0;
        mem_rd_addr = base_reg;
        mem_wr_en   = wb_valid_reg;
        mem_wr_addr = wb_addr_reg;
        mem_wr_data = sum_sat;

        if (wb_valid_reg)
        begin
            sat_next = sat_reg | sat_now;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.mode == MODE_READ)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DIFF;
                    end
                end
            end
            S_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                mem_wr_data   = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIFF:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                bin_next    = bin_calc;
                filled_next = fill_count;
                rem_next    = fill_count;
                sat_next    = 1'b0;
                if (skip_first)
                begin
                    base_next = ADDR_W'(ROW) + ADDR_W'(bin_calc);
                end
                else
                begin
                    base_next = ADDR_W'(bin_calc);
                end
                if (fill_count == '0)
                begin
                    result_next.bin_total     = '0;
                    result_next.histos_filled = '0;
                    result_next.bin_used      = bin_calc[NBIN_W-1:0];
                    result_next.saturated     = 1'b0;
                    done_next                 = 1'b1;
                    state_next                = S_IDLE;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                // One read issued per cycle; the previous entry is written
                // back in the same cycle at a different address.
                mem_rd_en     = 1'b1;
                mem_rd_addr   = base_reg;
                wb_valid_next = 1'b1;
                wb_addr_next  = base_reg;
                base_next     = base_reg + ADDR_W'(ROW);
                rem_next      = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                result_next.bin_total     = '0;
                result_next.histos_filled = filled_reg;
                result_next.bin_used      = bin_reg[NBIN_W-1:0];
                result_next.saturated     = sat_reg | sat_now;
                done_next                 = 1'b1;
                state_next                = S_IDLE;
            end
            S_READ:
            begin
                mem_rd_en   = rd_in_range;
                mem_rd_addr = rd_item_addr;
                rd_ok_next  = rd_in_range;
                state_next  = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                result_next.bin_total     = rd_ok_reg ? mem_rd_data : '0;
                result_next.histos_filled = '0;
                result_next.bin_used      = '0;
                result_next.saturated     = 1'b0;
                done_next                 = 1'b1;
                state_next                = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            wb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            wb_valid_reg <= wb_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        base_reg    <= base_next;
        rem_reg     <= rem_next;
        filled_reg  <= filled_next;
        bin_reg     <= bin_next;
        wb_addr_reg <= wb_addr_next;
        sat_reg     <= sat_next;
        rd_ok_reg   <= rd_ok_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A result transfer only follows the states that finish an item.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_SETUP || state_reg == S_FLUSH
                       || state_reg == S_READ_WAIT))
        else $error("result strobe without a finishing state");

    // The store is only written by the clearing pass or a fill write-back.
    a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == S_CLEAR || state_reg == S_FILL
                       || state_reg == S_FLUSH))
        else $error("bin store written outside clear or fill");

    // The last read of a fill must still be written back when flushing.
    a_flush_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> wb_valid_reg)
        else $error("flush without a pending write-back");

    // An accepted item keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

endmodule

### rtl/cwh_store.sv
module cwh_store #(
    parameter int DEPTH  = 1122,
    parameter int ADDR_W = 11
) (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [ADDR_W-1:0]              rd_addr,
    output logic signed [cwh_pkg::SUM_W-1:0] rd_data,
    input  logic                           wr_en,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic signed [cwh_pkg::SUM_W-1:0] wr_data
);
    import cwh_pkg::*;

    logic signed [SUM_W-1:0] mem [DEPTH];
    logic signed [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/cwh_binner.sv
module cwh_binner (
    input  logic                         clk,
    input  logic signed [31:0]           value,
    input  logic signed [31:0]           x_min,
    input  logic [31:0]                  bin_scale,
    input  logic [cwh_pkg::NBIN_W-1:0]   nb,
    output logic [cwh_pkg::BIN_W-1:0]    bin
);
    import cwh_pkg::*;

    // Two free-running stages: the offset from the lower edge, then the
    // Q32.32 product whose integer part is the raw bin number.
    logic signed [32:0] d_reg;
    logic signed [32:0] d_next;
    logic [63:0]        prod_reg;
    logic [63:0]        prod_next;
    logic               neg_reg;
    logic [31:0]        k;

    assign d_next    = 33'(value) - 33'(x_min);
    assign prod_next = 64'(d_reg[31:0]) * 64'(bin_scale);

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        prod_reg <= prod_next;
        neg_reg  <= d_reg[32];
    end

    assign k = prod_reg[63:32];

    always_comb
    begin
        if (neg_reg)
        begin
            bin = '0;
        end
        else if (k < 32'(nb))
        begin
            bin = BIN_W'(k) + BIN_W'(1);
        end
        else
        begin
            bin = BIN_W'(nb) + BIN_W'(1);
        end
    end

endmodule
